/* src/mrs_pkg.sv */
// Shared types and constants of the 3x3 spreading filter.
package mrs_pkg;

  localparam int PIX_W          = 8;
  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_IDX_W      = 2;
  localparam int ROW_W          = 13;
  localparam int HEIGHT_LIMIT   = 4096;
  localparam int WIDTH_RST      = 640;
  localparam int HEIGHT_RST     = 480;

  typedef logic [PIX_W-1:0] pix_t;

  localparam pix_t PIX_MAX = {PIX_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPREAD_MODE  = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    pix_t pixel_in;
    logic flush;
  } in_item_t;

  typedef struct packed {
    pix_t pixel_out;
    logic last_of_frame;
  } out_item_t;

  // Per-item control handed from the input register to the filter stage.
  typedef struct packed {
    pix_t px;
    logic emit_a;       // row start: previous row's last column completes
    logic emit_b;       // column to the left of this one completes
    logic row_ok_top;
    logic row_ok_bot;
    logic col_ok_left;
    logic col_ok_right;
    logic last;
  } stage_ctl_t;

endpackage

/* src/mrs_line_store.sv */
// Two-row line store: one wide memory with registered read and write bypass.
module mrs_line_store import mrs_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr_i,
  input  logic [2*PIX_W-1:0]           wr_data_i,
  output logic [2*PIX_W-1:0]           rd_data_o
);

  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;
  logic [2*PIX_W-1:0] fwd_q;
  logic               bypass_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q  <= mem[rd_addr_i];
      fwd_q <= wr_data_i;
    end
  end

  // Read of the entry written in the same cycle returns the new data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q <= 1'b0;
    end else if (rd_en_i) begin
      bypass_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = bypass_q ? fwd_q : rd_q;

  a_bypass_new_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_i && rd_en_i && (wr_addr_i == rd_addr_i)) |=> (rd_data_o == $past(wr_data_i)))
    else $error("line store read missed same-cycle write");

endmodule

/* src/mrs_ctrl.sv */
// Configuration registers, frame position counters and input register.
module mrs_ctrl import mrs_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                         accept_i,
  input  in_item_t                     in_item_i,
  input  logic                         adv_i,
  output logic                         spread_mode_o,
  output logic                         rd_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_addr_o,
  output logic                         s1_valid_o,
  output stage_ctl_t                   s1_ctl_o,
  output logic [$clog2(MAX_WIDTH)-1:0] s1_addr_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

  logic                   spread_q, spread_d;
  logic [WW-1:0]          w_eff_q, w_eff_d;
  logic [ROW_W-1:0]       h_eff_q, h_eff_d;
  logic [CW-1:0]          in_col_q, in_col_d;
  logic [ROW_W-1:0]       in_row_q, in_row_d;
  logic                   s1_valid_q, s1_valid_d;
  stage_ctl_t             s1_ctl_q, ctl_d;
  logic [CW-1:0]          s1_addr_q;

  logic                     cfg_restart;
  logic [FRAME_WIDTH_W-1:0] wr_w;
  logic [ROW_W-1:0]         wr_h;
  logic [WW-1:0]            col_next;
  logic                     has_pixel, proc, col_zero, row_end;

  // Configuration write: clamp to the supported range and restart the frame.
  always_comb begin
    spread_d    = spread_q;
    w_eff_d     = w_eff_q;
    h_eff_d     = h_eff_q;
    cfg_restart = 1'b0;
    wr_w        = cfg_wdata_i[FRAME_WIDTH_W-1:0];
    wr_h        = cfg_wdata_i[FRAME_HEIGHT_W-1:0];
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SPREAD_MODE: begin
          spread_d    = cfg_wdata_i[0];
          cfg_restart = 1'b1;
        end
        CFG_FRAME_WIDTH: begin
          if (wr_w == '0) begin
            w_eff_d = WW'(1);
          end else if (32'(wr_w) > MAX_WIDTH) begin
            w_eff_d = WW'(MAX_WIDTH);
          end else begin
            w_eff_d = WW'(wr_w);
          end
          cfg_restart = 1'b1;
        end
        CFG_FRAME_HEIGHT: begin
          if (wr_h == '0) begin
            h_eff_d = ROW_W'(1);
          end else if (wr_h > ROW_W'(HEIGHT_LIMIT)) begin
            h_eff_d = ROW_W'(HEIGHT_LIMIT);
          end else begin
            h_eff_d = wr_h;
          end
          cfg_restart = 1'b1;
        end
        default: begin
          cfg_restart = 1'b0;
        end
      endcase
    end
  end

  // Position decode of the offered item; rows past the frame are flush rows.
  always_comb begin
    col_next  = WW'(in_col_q) + WW'(1);
    has_pixel = in_row_q < h_eff_q;
    proc      = !(in_item_i.flush && has_pixel);
    col_zero  = in_col_q == '0;
    row_end   = col_next >= w_eff_q;

    ctl_d.px           = has_pixel ? in_item_i.pixel_in : '0;
    ctl_d.emit_a       = col_zero && (in_row_q >= ROW_W'(2));
    ctl_d.emit_b       = !col_zero && (in_row_q >= ROW_W'(1));
    ctl_d.row_ok_top   = col_zero ? (in_row_q >= ROW_W'(3)) : (in_row_q >= ROW_W'(2));
    ctl_d.row_ok_bot   = col_zero ? (in_row_q <= h_eff_q) : (in_row_q < h_eff_q);
    ctl_d.col_ok_left  = col_zero ? (w_eff_q >= WW'(2)) : (in_col_q >= CW'(2));
    ctl_d.col_ok_right = !col_zero;
    ctl_d.last         = ctl_d.emit_a && (in_row_q == h_eff_q + ROW_W'(1));

    in_col_d = in_col_q;
    in_row_d = in_row_q;
    if (cfg_restart) begin
      in_col_d = '0;
      in_row_d = '0;
    end else if (accept_i && proc) begin
      if (ctl_d.last) begin
        in_col_d = '0;
        in_row_d = '0;
      end else if (row_end) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_W'(1);
      end else begin
        in_col_d = col_next[CW-1:0];
      end
    end

    s1_valid_d = s1_valid_q;
    if (accept_i) begin
      s1_valid_d = proc;
    end else if (adv_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spread_q   <= 1'b0;
      w_eff_q    <= WW'(W_RST);
      h_eff_q    <= ROW_W'(HEIGHT_RST);
      in_col_q   <= '0;
      in_row_q   <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      spread_q   <= spread_d;
      w_eff_q    <= w_eff_d;
      h_eff_q    <= h_eff_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && proc) begin
      s1_ctl_q  <= ctl_d;
      s1_addr_q <= in_col_q;
    end
  end

  assign spread_mode_o = spread_q;
  assign rd_en_o       = accept_i && proc;
  assign rd_addr_o     = in_col_q;
  assign s1_valid_o    = s1_valid_q;
  assign s1_ctl_o      = s1_ctl_q;
  assign s1_addr_o     = s1_addr_q;

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(in_col_q) < w_eff_q)
    else $error("column counter beyond frame width");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_row_q <= h_eff_q + ROW_W'(1))
    else $error("row counter beyond last flush row");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && proc && ctl_d.last) |=> (in_col_q == '0 && in_row_q == '0))
    else $error("frame did not restart after its last pixel");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> (!s1_valid_q || adv_i))
    else $error("input register overwritten while holding an item");

endmodule

/* src/mrs_window.sv */
// Window columns, 3x3 spread decision and result register.
module mrs_window import mrs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       spread_mode_i,
  input  logic       s1_valid_i,
  input  stage_ctl_t s1_ctl_i,
  input  pix_t       rd_top_i,
  input  pix_t       rd_mid_i,
  input  logic       out_stall_i,
  output logic       adv_o,
  output logic       out_valid_o,
  output out_item_t  out_item_o
);

  // Rows: 0 top, 1 middle, 2 bottom. Only the two newest columns are kept; the incoming
  // column (top and middle from the line store, bottom from the input pixel) is the right neighbor.
  pix_t      win_left_q [3];
  pix_t      win_ctr_q  [3];
  pix_t      new_col    [3];
  logic      row_ok     [3];
  pix_t      target;
  logic      hit;
  logic      out_valid_q;
  out_item_t out_item_q, out_item_d;
  logic      adv;

  always_comb begin
    target     = spread_mode_i ? PIX_MAX : '0;
    new_col[0] = rd_top_i;
    new_col[1] = rd_mid_i;
    new_col[2] = s1_ctl_i.px;
    row_ok[0]  = s1_ctl_i.row_ok_top;
    row_ok[1]  = 1'b1;
    row_ok[2]  = s1_ctl_i.row_ok_bot;
    hit        = 1'b0;
    for (int r = 0; r < 3; r++) begin
      if (row_ok[r]) begin
        if ((s1_ctl_i.col_ok_left && (win_left_q[r] == target)) ||
            (win_ctr_q[r] == target) ||
            (s1_ctl_i.col_ok_right && (new_col[r] == target))) begin
          hit = 1'b1;
        end
      end
    end
    out_item_d.pixel_out     = hit ? target : win_ctr_q[1];
    out_item_d.last_of_frame = s1_ctl_i.last;
  end

  assign adv = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        win_left_q[r] <= '0;
        win_ctr_q[r]  <= '0;
      end
      out_valid_q <= 1'b0;
    end else if (adv) begin
      if (s1_valid_i) begin
        for (int r = 0; r < 3; r++) begin
          win_left_q[r] <= win_ctr_q[r];
          win_ctr_q[r]  <= new_col[r];
        end
      end
      out_valid_q <= s1_valid_i && (s1_ctl_i.emit_a || s1_ctl_i.emit_b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_i) begin
      out_item_q <= out_item_d;
    end
  end

  assign adv_o       = adv;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* src/morphology_3x3_spread.sv */
// Result: a pixel's result leaves through the input register and the result register once
//   the item that completes its 3x3 neighborhood is accepted, i.e. frame_width+1 items after the pixel.
// Throughput: 1 item per cycle while the output is not stalled; the line store reads and
//   writes one column entry per cycle on separate ports.
// Reset: mode 0, width 640 (clamped to MAX_WIDTH), height 480, frame start;
//   line stores are not cleared, since stale entries are always masked.
module morphology_3x3_spread import mrs_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic               accept, adv, spread_mode;
  logic               rd_en, s1_valid;
  logic [CW-1:0]      rd_addr, s1_addr;
  stage_ctl_t         s1_ctl;
  logic [2*PIX_W-1:0] rd_data, wr_data;

  assign in_stall_o = s1_valid && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  mrs_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .in_item_i     (in_item_i),
    .adv_i         (adv),
    .spread_mode_o (spread_mode),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .s1_valid_o    (s1_valid),
    .s1_ctl_o      (s1_ctl),
    .s1_addr_o     (s1_addr)
  );

  // Older row moves down: older <= newer, newer <= incoming pixel.
  assign wr_data = {rd_data[PIX_W-1:0], s1_ctl.px};

  mrs_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (adv && s1_valid),
    .wr_addr_i (s1_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  mrs_window u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .spread_mode_i (spread_mode),
    .s1_valid_i    (s1_valid),
    .s1_ctl_i      (s1_ctl),
    .rd_top_i      (rd_data[2*PIX_W-1:PIX_W]),
    .rd_mid_i      (rd_data[PIX_W-1:0]),
    .out_stall_i   (out_stall_i),
    .adv_o         (adv),
    .out_valid_o   (out_valid_o),
    .out_item_o    (out_item_o)
  );

endmodule
